[design/rcp_pkg.sv]
package rcp_pkg;

  // Widths fixed by the input byte and the result word
  localparam int unsigned ByteW  = 8;
  localparam int unsigned EventW = 2;
  localparam int unsigned TokenW = 32;

  // Default width of decoded counts and lengths
  localparam int unsigned LengthBitsDef = 32;

  // Characters of the wire format
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChDollar = 8'h24;

  typedef enum logic [EventW-1:0] {
    EvName  = 2'd0,
    EvArg   = 2'd1,
    EvError = 2'd2,
    EvEmpty = 2'd3
  } event_e;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [TokenW-1:0] token_offset;
    logic [TokenW-1:0] token_length;
    logic [TokenW-1:0] arg_total;
    logic              last_token;
  } res_t;

endpackage

[design/rcp_if.sv]
interface rcp_in_if;
  logic                      valid;
  logic                      ready;
  logic [rcp_pkg::ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rcp_out_if;
  logic                       valid;
  logic                       ready;
  logic [rcp_pkg::EventW-1:0] event_res;
  logic [rcp_pkg::TokenW-1:0] token_offset;
  logic [rcp_pkg::TokenW-1:0] token_length;
  logic [rcp_pkg::TokenW-1:0] arg_total;
  logic                       last_token;

  modport source (output valid, output event_res, output token_offset, output token_length,
                  output arg_total, output last_token, input ready);
  modport sink   (input valid, input event_res, input token_offset, input token_length,
                  input arg_total, input last_token, output ready);
endinterface

[design/rcp_in_stage.sv]
module rcp_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [rcp_pkg::ByteW-1:0] byte_i,
  output logic                      ready_o,
  input  logic                      pop_i,
  output logic                      valid_o,
  output logic [rcp_pkg::ByteW-1:0] byte_o
);

  logic                      valid_q;
  logic [rcp_pkg::ByteW-1:0] byte_q;

  // Take a new word when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || pop_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

[design/rcp_parse.sv]
module rcp_parse #(
  parameter int unsigned LENGTH_BITS = rcp_pkg::LengthBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [rcp_pkg::ByteW-1:0] byte_i,
  input  logic                      step_i,
  output logic                      has_res_o,
  output rcp_pkg::res_t             res_o
);

  localparam int unsigned AccW = LENGTH_BITS + 4;

  typedef enum logic [3:0] {
    PhCountFirst  = 4'd0,
    PhCountDigits = 4'd1,
    PhCountLf     = 4'd2,
    PhDollar      = 4'd3,
    PhLenFirst    = 4'd4,
    PhLenDigits   = 4'd5,
    PhLenLf       = 4'd6,
    PhContent     = 4'd7,
    PhEndCr       = 4'd8,
    PhEndLf       = 4'd9
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [LENGTH_BITS-1:0]      args_q, args_d;
  logic [LENGTH_BITS-1:0]      acc_q, acc_d;
  logic [LENGTH_BITS-1:0]      content_q, content_d;
  logic [rcp_pkg::TokenW-1:0]  pos_q, pos_d;
  logic [rcp_pkg::TokenW-1:0]  start_q, start_d;
  logic                        name_q, name_d;

  logic                        is_digit;
  logic [3:0]                  digit;
  logic [AccW-1:0]             acc10;
  logic                        acc_ovf;
  logic [LENGTH_BITS-1:0]      args_dec;
  logic [LENGTH_BITS-1:0]      content_dec;
  logic                        clr;
  logic                        res_v;
  rcp_pkg::res_t               res;

  assign is_digit = (byte_i >= rcp_pkg::ChZero) && (byte_i <= rcp_pkg::ChNine);
  assign digit    = byte_i[3:0];
  // acc * 10 + digit; any bit above the length width is an overflow
  assign acc10    = (AccW'(acc_q) << 3) + (AccW'(acc_q) << 1) + AccW'(digit);
  assign acc_ovf  = |acc10[AccW-1:LENGTH_BITS];
  assign args_dec = (args_q != '0) ? args_q - LENGTH_BITS'(1) : args_q;
  assign content_dec = content_q - LENGTH_BITS'(1);

  always_comb begin
    phase_d   = phase_q;
    args_d    = args_q;
    acc_d     = acc_q;
    content_d = content_q;
    pos_d     = pos_q + rcp_pkg::TokenW'(1);
    start_d   = start_q;
    name_d    = name_q;
    clr       = 1'b0;
    res_v     = 1'b0;
    res       = '0;

    unique case (phase_q)
      PhCountDigits, PhLenDigits: begin
        if (is_digit) begin
          if (acc_ovf) begin
            clr   = 1'b1;
            res_v = 1'b1;
            res.event_res = rcp_pkg::EvError;
          end else begin
            acc_d = acc10[LENGTH_BITS-1:0];
          end
        end else if (byte_i == rcp_pkg::ChCr) begin
          phase_d = (phase_q == PhCountDigits) ? PhCountLf : PhLenLf;
        end else begin
          clr   = 1'b1;
          res_v = 1'b1;
          res.event_res = rcp_pkg::EvError;
        end
      end
      PhCountLf: begin
        res_v = 1'b1;
        if (byte_i != rcp_pkg::ChLf) begin
          clr = 1'b1;
          res.event_res = rcp_pkg::EvError;
        end else if (acc_q == '0) begin
          clr = 1'b1;
          res.event_res  = rcp_pkg::EvEmpty;
          res.last_token = 1'b1;
        end else begin
          res_v   = 1'b0;
          args_d  = acc_q - LENGTH_BITS'(1);
          name_d  = 1'b1;
          phase_d = PhDollar;
        end
      end
      PhDollar: begin
        if (byte_i != rcp_pkg::ChDollar) begin
          clr   = 1'b1;
          res_v = 1'b1;
          res.event_res = rcp_pkg::EvError;
        end else begin
          phase_d = PhLenFirst;
        end
      end
      PhLenFirst: begin
        if (!is_digit) begin
          clr   = 1'b1;
          res_v = 1'b1;
          res.event_res = rcp_pkg::EvError;
        end else begin
          acc_d   = LENGTH_BITS'(digit);
          phase_d = PhLenDigits;
        end
      end
      PhLenLf: begin
        if (byte_i != rcp_pkg::ChLf) begin
          clr   = 1'b1;
          res_v = 1'b1;
          res.event_res = rcp_pkg::EvError;
        end else begin
          content_d = acc_q;
          start_d   = pos_q + rcp_pkg::TokenW'(1);
          phase_d   = (acc_q == '0) ? PhEndCr : PhContent;
        end
      end
      PhContent: begin
        content_d = content_dec;
        if (content_dec == '0) begin
          phase_d = PhEndCr;
        end
      end
      PhEndCr: begin
        if (byte_i != rcp_pkg::ChCr) begin
          clr   = 1'b1;
          res_v = 1'b1;
          res.event_res = rcp_pkg::EvError;
        end else begin
          phase_d = PhEndLf;
        end
      end
      PhEndLf: begin
        res_v = 1'b1;
        if (byte_i != rcp_pkg::ChLf) begin
          clr = 1'b1;
          res.event_res = rcp_pkg::EvError;
        end else begin
          res.token_offset = start_q;
          res.token_length = rcp_pkg::TokenW'(acc_q);
          phase_d = PhDollar;
          if (name_q) begin
            res.event_res  = rcp_pkg::EvName;
            res.arg_total  = rcp_pkg::TokenW'(args_q);
            res.last_token = (args_q == '0);
            name_d = 1'b0;
          end else begin
            res.event_res  = rcp_pkg::EvArg;
            res.last_token = (args_dec == '0);
            args_d = args_dec;
          end
          clr = res.last_token;
        end
      end
      default: begin
        // Idle: first digit of the element count opens a command
        if (!is_digit) begin
          clr   = 1'b1;
          res_v = 1'b1;
          res.event_res = rcp_pkg::EvError;
        end else begin
          phase_d   = PhCountDigits;
          args_d    = '0;
          acc_d     = LENGTH_BITS'(digit);
          content_d = '0;
          pos_d     = rcp_pkg::TokenW'(1);
          start_d   = '0;
          name_d    = 1'b1;
        end
      end
    endcase

    // Drop the command and return to idle
    if (clr) begin
      phase_d   = PhCountFirst;
      args_d    = '0;
      acc_d     = '0;
      content_d = '0;
      pos_d     = '0;
      start_d   = '0;
      name_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhCountFirst;
      args_q    <= '0;
      acc_q     <= '0;
      content_q <= '0;
      pos_q     <= '0;
      start_q   <= '0;
      name_q    <= 1'b1;
    end else if (step_i) begin
      phase_q   <= phase_d;
      args_q    <= args_d;
      acc_q     <= acc_d;
      content_q <= content_d;
      pos_q     <= pos_d;
      start_q   <= start_d;
      name_q    <= name_d;
    end
  end

  assign has_res_o = valid_i && res_v;
  assign res_o     = res;

endmodule

[design/rcp_out_stage.sv]
module rcp_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  rcp_pkg::res_t res_i,
  output logic          free_o,
  output logic          valid_o,
  input  logic          ready_i,
  output rcp_pkg::res_t res_o
);

  logic          valid_q;
  rcp_pkg::res_t res_q;

  // Free when empty or when the held word is taken this cycle
  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

[design/resp_command_parser_core.sv]
// Byte-serial parser for commands sent as arrays of bulk strings, with the
// leading array marker already stripped. Each accepted word is one byte of
// the stream; the block takes one byte per cycle and reports at most one
// result word per byte: the name token with its argument count, each
// argument token (offset from the command start and length), an empty
// command, or a malformed byte, after which it drops back to idle. A byte
// passes an input register, the parser state update and a result register
// before its result is presented. Throughput is one byte per cycle while
// results are taken; a byte that yields a result waits in the input register
// while the result register is full, and input ready then follows output
// ready in the same cycle.
module resp_command_parser_core #(
  parameter int unsigned LENGTH_BITS = rcp_pkg::LengthBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rcp_in_if.sink     in_i,
  rcp_out_if.source  res_o
);

  logic                      s1_valid;
  logic [rcp_pkg::ByteW-1:0] s1_byte;
  logic                      step;
  logic                      has_res;
  logic                      out_free;
  rcp_pkg::res_t             res;
  rcp_pkg::res_t             res_held;

  // Hold the input word
  rcp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .byte_i  (in_i.data_byte),
    .ready_o (in_i.ready),
    .pop_i   (step),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  // Advance the parser unless its result has nowhere to go
  assign step = s1_valid && (!has_res || out_free);

  rcp_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .byte_i    (s1_byte),
    .step_i    (step),
    .has_res_o (has_res),
    .res_o     (res)
  );

  // Register the result word
  rcp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && has_res),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (res_held)
  );

  assign res_o.event_res    = res_held.event_res;
  assign res_o.token_offset = res_held.token_offset;
  assign res_o.token_length = res_held.token_length;
  assign res_o.arg_total    = res_held.arg_total;
  assign res_o.last_token   = res_held.last_token;

endmodule
